@@ hdl/afb_pkg.sv @@
`timescale 1ns / 1ps

package afb_pkg;

	// Sigmoid table size and its address width
	localparam int unsigned SIG_ENTRIES = 256;
	localparam int unsigned IDX_W       = $clog2(SIG_ENTRIES);

	// Q4.12 word, sigmoid sample (0..4096), activation (-4096..4096)
	localparam int unsigned DATA_W  = 16;
	localparam int unsigned SIG_W   = 13;
	localparam int unsigned ACT_W   = 14;
	localparam int unsigned DERIV_W = 25;
	localparam int unsigned PROD_W  = DATA_W + DERIV_W + 1;

	typedef enum logic [1:0] {
		FUNC_IDENT   = 2'd0,
		FUNC_RELU    = 2'd1,
		FUNC_SIGMOID = 2'd2,
		FUNC_TANH    = 2'd3
	} func_t;

	// e^(-a/4096) in Q0.32: alternating Taylor series of e^(-a/65536), then squared four times
	function automatic logic [31:0] exp_neg_q32(input logic [31:0] a);
		logic [63:0] r;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] y;
		r    = {16'h0000, a, 16'h0000};
		term = 64'h0000_0001_0000_0000;
		sum  = term;
		term = (term * r) >> 32;
		sum  = (sum >= term) ? sum - term : 64'd0;
		term = ((term * r) >> 32) / 2;
		sum  = sum + term;
		term = ((term * r) >> 32) / 3;
		sum  = (sum >= term) ? sum - term : 64'd0;
		term = ((term * r) >> 32) / 4;
		sum  = sum + term;
		term = ((term * r) >> 32) / 5;
		sum  = (sum >= term) ? sum - term : 64'd0;
		term = ((term * r) >> 32) / 6;
		sum  = sum + term;
		term = ((term * r) >> 32) / 7;
		sum  = (sum >= term) ? sum - term : 64'd0;
		term = ((term * r) >> 32) / 8;
		sum  = sum + term;
		term = ((term * r) >> 32) / 9;
		sum  = (sum >= term) ? sum - term : 64'd0;
		term = ((term * r) >> 32) / 10;
		sum  = sum + term;
		term = ((term * r) >> 32) / 11;
		sum  = (sum >= term) ? sum - term : 64'd0;
		term = ((term * r) >> 32) / 12;
		sum  = sum + term;
		y = (sum > 64'h0000_0000_FFFF_FFFF) ? 64'h0000_0000_FFFF_FFFF : sum;
		for (int n = 0; n < 4; n++) begin
			y = (y * y + 64'h0000_0000_8000_0000) >> 32;
		end
		return y[31:0];
	endfunction

	// Table entry i: sigmoid sampled at floor(i*65536/SIG_ENTRIES) - 32768, Q.12
	function automatic logic [SIG_W-1:0] sig_entry(input int unsigned i);
		logic [63:0] pos;
		int          xs;
		logic [31:0] a;
		logic [63:0] den;
		logic [63:0] num;
		logic [63:0] rem;
		logic [45:0] quo;
		logic [45:0] sp;
		pos = (64'(i) * 64'd65536) / 64'(SIG_ENTRIES);
		xs  = int'(pos[31:0]) - 32768;
		a   = (xs < 0) ? 32'(-xs) : 32'(xs);
		den = 64'h0000_0001_0000_0000 + 64'(exp_neg_q32(a));
		num = 64'h0000_1000_0000_0000 + (den >> 1);
		rem = 64'd0;
		quo = 46'd0;
		// restoring long division, one quotient bit per pass
		for (int b = 45; b >= 0; b--) begin
			rem = {rem[62:0], num[b]};
			if (rem >= den) begin
				rem    = rem - den;
				quo[b] = 1'b1;
			end
		end
		sp = (quo > 46'd4096) ? 46'd4096 : quo;
		return (xs < 0) ? SIG_W'(46'd4096 - sp) : SIG_W'(sp);
	endfunction

endpackage

@@ hdl/afb_round_sat.sv @@
`timescale 1ns / 1ps

// Shift a Q6.36 product down by 24 to Q4.12, round half away from zero, saturate to 16 bits.
module afb_round_sat (
	input  logic signed [afb_pkg::PROD_W-1:0] prod,
	output logic signed [afb_pkg::DATA_W-1:0] result
);

	localparam int unsigned RND_W = afb_pkg::PROD_W - 24;

	logic [afb_pkg::PROD_W-1:0] mag;
	logic [afb_pkg::PROD_W-1:0] biased;
	logic [RND_W-1:0]           rnd;

	always_comb begin
		mag    = prod[afb_pkg::PROD_W-1] ? afb_pkg::PROD_W'(-prod) : afb_pkg::PROD_W'(prod);
		biased = mag + afb_pkg::PROD_W'(24'h80_0000);
		rnd    = biased[afb_pkg::PROD_W-1:24];
		if (prod[afb_pkg::PROD_W-1]) begin
			if (rnd >= RND_W'(32768)) begin
				result = 16'sh8000;
			end else begin
				result = afb_pkg::DATA_W'(-rnd);
			end
		end else begin
			if (rnd > RND_W'(32767)) begin
				result = 16'sh7FFF;
			end else begin
				result = afb_pkg::DATA_W'(rnd);
			end
		end
	end

endmodule

@@ hdl/activation_forward_backward_unit.sv @@
`timescale 1ns / 1ps

// Channel  | Dir | Handshake                    | Payload
// ---------+-----+------------------------------+-----------------------------------------
// s_axis   | in  | s_axis_tvalid/s_axis_tready  | tdata: x_value[15:0], grad_in[31:16]
//          |     |                              | tuser: func[1:0], backward[2]
// m_axis   | out | m_axis_tvalid/m_axis_tready  | tdata: result[15:0]
//
// Throughput is one beat per clock unless m_axis_tready stalls the output; a beat passes every stage below.
// The five register stages are: table address, sigmoid lookup, derivative multiply,
// gradient multiply, round/saturate into the output register.
// arst_n clears every stage valid bit at once; the data registers are not reset.
// On a stall each stage holds unless the stage after it is empty or moving, so empty
// slots (bubbles) are squeezed out and no beat is dropped or repeated.

module activation_forward_backward_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // x_value[15:0], grad_in[31:16]
	input  logic [2:0]  s_axis_tuser,   // func[1:0], backward[2]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata    // result[15:0]
);

	localparam int unsigned IDX_PROD_W = afb_pkg::DATA_W + afb_pkg::IDX_W;

	// Constant sigmoid table, one entry per sample point
	logic [afb_pkg::SIG_W-1:0] sig_tab [afb_pkg::SIG_ENTRIES];

	for (genvar g = 0; g < afb_pkg::SIG_ENTRIES; g++) begin : g_tab
		localparam logic [afb_pkg::SIG_W-1:0] ENTRY = afb_pkg::sig_entry(g);
		assign sig_tab[g] = ENTRY;
	end

	// Stage enables: a stage may load when it is empty or its content moves on
	logic adv1;
	logic adv2;
	logic adv3;
	logic adv4;
	logic adv5;

	logic valid_s1;
	logic valid_s2;
	logic valid_s3;
	logic valid_s4;
	logic valid_s5;

	assign adv5 = !valid_s5 || m_axis_tready;
	assign adv4 = !valid_s4 || adv5;
	assign adv3 = !valid_s3 || adv4;
	assign adv2 = !valid_s2 || adv3;
	assign adv1 = !valid_s1 || adv2;

	assign s_axis_tready = adv1;
	assign m_axis_tvalid = valid_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (adv1) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (adv2) begin
				valid_s2 <= valid_s1;
			end
			if (adv3) begin
				valid_s3 <= valid_s2;
			end
			if (adv4) begin
				valid_s4 <= valid_s3;
			end
			if (adv5) begin
				valid_s5 <= valid_s4;
			end
		end
	end

	// ---------------- Stage 1: table address and range clamp ----------------
	afb_pkg::func_t              in_func;
	logic signed [15:0]          in_x;
	logic signed [16:0]          lut_arg;
	logic [15:0]                 lut_off;
	logic [IDX_PROD_W-1:0]       lut_scaled;

	afb_pkg::func_t              func_s1;
	logic                        bwd_s1;
	logic signed [15:0]          x_s1;
	logic signed [15:0]          u_s1;
	logic [afb_pkg::IDX_W-1:0]   idx_s1;
	logic                        below_s1;
	logic                        above_s1;

	always_comb begin
		in_func = afb_pkg::func_t'(s_axis_tuser[1:0]);
		in_x    = s_axis_tdata[15:0];
		// tanh looks up sig(2x), the other functions sig(x)
		if (in_func == afb_pkg::FUNC_TANH) begin
			lut_arg = {in_x, 1'b0};
		end else begin
			lut_arg = {in_x[15], in_x};
		end
		// flip the sign bit to get the offset from -8.0
		lut_off    = lut_arg[15:0] ^ 16'h8000;
		lut_scaled = IDX_PROD_W'(lut_off) * IDX_PROD_W'(afb_pkg::SIG_ENTRIES);
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			func_s1  <= in_func;
			bwd_s1   <= s_axis_tuser[2];
			x_s1     <= in_x;
			u_s1     <= s_axis_tdata[31:16];
			idx_s1   <= lut_scaled[IDX_PROD_W-1:afb_pkg::DATA_W];
			below_s1 <= lut_arg[16] && !lut_arg[15];
			above_s1 <= !lut_arg[16] && lut_arg[15];
		end
	end

	// ---------------- Stage 2: sigmoid lookup, forward activation ----------------
	logic [afb_pkg::SIG_W-1:0]        sig_val;
	logic signed [afb_pkg::ACT_W-1:0] act_val;

	afb_pkg::func_t                   func_s2;
	logic                             bwd_s2;
	logic signed [15:0]               x_s2;
	logic signed [15:0]               u_s2;
	logic signed [afb_pkg::ACT_W-1:0] act_s2;

	always_comb begin
		if (below_s1) begin
			sig_val = '0;
		end else if (above_s1) begin
			sig_val = afb_pkg::SIG_W'(4096);
		end else begin
			sig_val = sig_tab[idx_s1];
		end
		// tanh = 2*sig(2x) - 1
		if (func_s1 == afb_pkg::FUNC_TANH) begin
			act_val = afb_pkg::ACT_W'({sig_val, 1'b0}) - afb_pkg::ACT_W'(4096);
		end else begin
			act_val = afb_pkg::ACT_W'(sig_val);
		end
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			func_s2 <= func_s1;
			bwd_s2  <= bwd_s1;
			x_s2    <= x_s1;
			u_s2    <= u_s1;
			act_s2  <= act_val;
		end
	end

	// ---------------- Stage 3: derivative and direct result ----------------
	logic [afb_pkg::SIG_W-1:0]     mul_a;
	logic [afb_pkg::SIG_W-1:0]     mul_b;
	logic [2*afb_pkg::SIG_W-1:0]   mul_ab;
	logic [afb_pkg::DERIV_W-1:0]   deriv;
	logic [afb_pkg::ACT_W-1:0]     act_abs;
	logic                          x_pos;
	logic signed [15:0]            direct;

	logic                          use_prod_s3;
	logic signed [15:0]            u_s3;
	logic [afb_pkg::DERIV_W-1:0]   deriv_s3;
	logic signed [15:0]            direct_s3;

	always_comb begin
		act_abs = act_s2[afb_pkg::ACT_W-1] ? afb_pkg::ACT_W'(-act_s2) : afb_pkg::ACT_W'(act_s2);
		// sigmoid: s*(1-s); tanh: 1 - t*t (|t| squared)
		if (func_s2 == afb_pkg::FUNC_TANH) begin
			mul_a = act_abs[afb_pkg::SIG_W-1:0];
			mul_b = act_abs[afb_pkg::SIG_W-1:0];
		end else begin
			mul_a = act_s2[afb_pkg::SIG_W-1:0];
			mul_b = afb_pkg::SIG_W'(4096) - act_s2[afb_pkg::SIG_W-1:0];
		end
		mul_ab = (2*afb_pkg::SIG_W)'(mul_a) * (2*afb_pkg::SIG_W)'(mul_b);
		if (func_s2 == afb_pkg::FUNC_TANH) begin
			deriv = afb_pkg::DERIV_W'(25'h100_0000) - mul_ab[afb_pkg::DERIV_W-1:0];
		end else begin
			deriv = mul_ab[afb_pkg::DERIV_W-1:0];
		end

		x_pos = !x_s2[15] && (x_s2 != 16'sd0);
		case (func_s2)
			afb_pkg::FUNC_IDENT: begin
				direct = bwd_s2 ? u_s2 : x_s2;
			end
			afb_pkg::FUNC_RELU: begin
				if (x_pos) begin
					direct = bwd_s2 ? u_s2 : x_s2;
				end else begin
					direct = 16'sd0;
				end
			end
			afb_pkg::FUNC_SIGMOID, afb_pkg::FUNC_TANH: begin
				direct = 16'(act_s2);
			end
			default: begin
				direct = 16'sd0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv3) begin
			use_prod_s3 <= bwd_s2 && func_s2[1];
			u_s3        <= u_s2;
			deriv_s3    <= deriv;
			direct_s3   <= direct;
		end
	end

	// ---------------- Stage 4: gradient times derivative ----------------
	logic                                 use_prod_s4;
	logic signed [afb_pkg::PROD_W-1:0]    prod_s4;
	logic signed [15:0]                   direct_s4;

	always_ff @(posedge clk) begin
		if (adv4) begin
			use_prod_s4 <= use_prod_s3;
			prod_s4     <= afb_pkg::PROD_W'(u_s3) * $signed({1'b0, deriv_s3});
			direct_s4   <= direct_s3;
		end
	end

	// ---------------- Stage 5: round, saturate, output register ----------------
	logic signed [15:0] rounded;
	logic [15:0]        result_s5;

	afb_round_sat u_round (
		.prod   (prod_s4),
		.result (rounded)
	);

	always_ff @(posedge clk) begin
		if (adv5) begin
			result_s5 <= use_prod_s4 ? rounded : direct_s4;
		end
	end

	assign m_axis_tdata = result_s5;

endmodule

@@ hdl/afb_checker.sv @@
`timescale 1ns / 1ps

module afb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata
);

	// output beat stays offered until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("output beat withdrawn before it was taken");

	// stalled output data holds
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("output data changed during a stall");

	// empty output register means the pipe can take a beat
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled while the output register is empty");

	// a moving output means the whole pipe moves
	a_ready_when_drain: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tready |-> s_axis_tready)
		else $error("input stalled while the output is being taken");

endmodule

bind activation_forward_backward_unit afb_checker u_afb_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
